[src/clean_first_lru_victim_select_core_defines.svh]
// assertion macros shared by the replacement block
`ifndef CLEAN_FIRST_LRU_VICTIM_SELECT_CORE_DEFINES_SVH
`define CLEAN_FIRST_LRU_VICTIM_SELECT_CORE_DEFINES_SVH

// same-cycle implication
`define CLF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("clf assertion failed");

// next-cycle implication
`define CLF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("clf assertion failed");

`endif

[src/clf_pkg.sv]
package clf_pkg;

   localparam int DEF_WAYS       = 8;
   localparam int DEF_SETS       = 64;
   localparam int DEF_STAMP_BITS = 48;

   localparam int OP_W      = 2;
   localparam int SET_IDX_W = 6;
   localparam int WAY_W     = 3;
   localparam int NOW_W     = 48;
   localparam int MASK_W    = 8;
   localparam int MAX_WAYS  = 32;

   typedef enum logic [OP_W-1:0] {
      OP_TOUCH      = 2'd0,
      OP_INSERT     = 2'd1,
      OP_INVALIDATE = 2'd2,
      OP_VICTIM     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOOK = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   typedef struct packed {
      logic             done;
      logic [WAY_W-1:0] way;
      logic             fallback;
   } scan_res_type;

endpackage

[src/clf_stamp_mem.sv]
module clf_stamp_mem #(
   parameter  int SETS   = clf_pkg::DEF_SETS,
   parameter  int ROW_W  = clf_pkg::DEF_WAYS * clf_pkg::DEF_STAMP_BITS,
   localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [SET_AW-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [SET_AW-1:0] wr_addr,
   input  logic [ROW_W-1:0]  wr_row,
   output logic [ROW_W-1:0]  rd_row
);
   import clf_pkg::*;

   logic [ROW_W-1:0] mem [SETS];
   logic [SETS-1:0]  row_valid_ff;
   logic [ROW_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   // one valid bit per set row, a row never written reads as all zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

[src/clf_scan.sv]
module clf_scan #(
   parameter  int WAYS       = clf_pkg::DEF_WAYS,
   parameter  int STAMP_BITS = clf_pkg::DEF_STAMP_BITS,
   localparam int WAY_AW     = $clog2(WAYS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [WAYS*STAMP_BITS-1:0]    row,
   input  logic [clf_pkg::MASK_W-1:0]    dirty_mask,
   output clf_pkg::scan_res_type         res
);
   import clf_pkg::*;

   logic [WAYS*STAMP_BITS-1:0] row_ff;
   logic [WAYS-1:0]            dirty_ff;
   logic [MAX_WAYS-1:0]        mask_ext;
   logic [WAY_AW-1:0]          idx_ff;
   logic                       active_ff;
   logic                       done_ff;
   logic [STAMP_BITS:0]        best_key_ff;
   logic [WAY_AW-1:0]          best_way_ff;
   logic [STAMP_BITS:0]        cand_key;
   logic                       take;

   // ways above the mask width count as clean
   assign mask_ext = MAX_WAYS'(dirty_mask);

   // dirty bit on top of the key puts every clean way ahead of every dirty one
   assign cand_key = {dirty_ff[0], row_ff[STAMP_BITS-1:0]};
   assign take     = (idx_ff == '0) || (cand_key < best_key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         idx_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            active_ff <= 1'b1;
            idx_ff    <= '0;
         end else if (active_ff) begin
            if (idx_ff == WAY_AW'(WAYS - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff   <= row;
         dirty_ff <= mask_ext[WAYS-1:0];
      end else if (active_ff) begin
         row_ff   <= row_ff >> STAMP_BITS;
         dirty_ff <= dirty_ff >> 1;
         if (take) begin
            best_key_ff <= cand_key;
            best_way_ff <= idx_ff;
         end
      end
   end

   assign res.done     = done_ff;
   assign res.way      = WAY_W'(best_way_ff);
   assign res.fallback = best_key_ff[STAMP_BITS];

endmodule

[src/clean_first_lru_victim_select_core.sv]
// clean-first lru replacement state for a set-associative cache
// input channel: a transaction is taken at a rising edge with start high and busy
//   low; op, set_index, way, now and dirty_mask are sampled there
// touch and insert store now (cut to STAMP_BITS) as the way's last-use stamp;
//   invalidate changes nothing; a victim query returns the oldest clean way,
//   or the oldest way overall with the fallback flag when every way is dirty
// result channel: every transaction gives exactly one result, held on the rsp_
//   ports for one cycle while rsp_strobe is high; the receiver cannot stall
// touch, insert and invalidate: the request passes ST_LOOK, which sets the
//   registered result strobe; the next transaction can be taken while it is high
// victim query: passes ST_LOOK and ST_SCAN, result registered at scan end; the
//   stamps of a set are compared one way per cycle through a single comparator
// stamps sit in one memory, one row per set with all ways, with a registered read;
//   an update reads the row and writes it back the next cycle
// reset clears the per-row valid bits at once, so every stamp reads as zero
//   right after reset; no clearing pass is needed
module clean_first_lru_victim_select_core #(
   parameter int WAYS       = clf_pkg::DEF_WAYS,
   parameter int SETS       = clf_pkg::DEF_SETS,
   parameter int STAMP_BITS = clf_pkg::DEF_STAMP_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [clf_pkg::OP_W-1:0]      req_op,
   input  logic [clf_pkg::SET_IDX_W-1:0] req_set_index,
   input  logic [clf_pkg::WAY_W-1:0]     req_way,
   input  logic [clf_pkg::NOW_W-1:0]     req_now,
   input  logic [clf_pkg::MASK_W-1:0]    req_dirty_mask,
   output logic                          rsp_strobe,
   output logic [clf_pkg::WAY_W-1:0]     rsp_victim_way,
   output logic                          rsp_victim_valid,
   output logic                          rsp_all_dirty_fallback
);
   import clf_pkg::*;

   `include "clean_first_lru_victim_select_core_defines.svh"

   localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_AW = $clog2(WAYS);
   localparam int ROW_W  = WAYS * STAMP_BITS;

   state_type              state_ff, state_in;
   op_type                 op_ff;
   logic [SET_IDX_W-1:0]   set_ff;
   logic [WAY_W-1:0]       way_ff;
   logic [STAMP_BITS-1:0]  now_ff;
   logic [MASK_W-1:0]      mask_ff;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [WAY_W-1:0]       rsp_way_ff, rsp_way_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_fb_ff, rsp_fb_in;

   logic                   accept;
   logic                   set_ok;
   logic                   way_ok;
   logic                   is_update;
   logic                   is_victim;
   logic                   wr_en;
   logic                   scan_load;
   logic [ROW_W-1:0]       rd_row;
   logic [ROW_W-1:0]       wr_row;
   scan_res_type           scan_res;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign set_ok    = (32'(set_ff) < 32'(SETS));
   assign way_ok    = (32'(way_ff) < 32'(WAYS));
   assign is_update = (op_ff == OP_TOUCH) || (op_ff == OP_INSERT);
   assign is_victim = (op_ff == OP_VICTIM);

   assign wr_en     = (state_ff == ST_LOOK) && is_update && set_ok && way_ok;
   assign scan_load = (state_ff == ST_LOOK) && is_victim && set_ok;

   // merge the new stamp into the row that was just read
   always_comb begin
      wr_row = rd_row;
      wr_row[WAY_AW'(way_ff) * STAMP_BITS +: STAMP_BITS] = now_ff;
   end

   clf_stamp_mem #(
      .SETS  (SETS),
      .ROW_W (ROW_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (SET_AW'(req_set_index)),
      .wr_en   (wr_en),
      .wr_addr (SET_AW'(set_ff)),
      .wr_row  (wr_row),
      .rd_row  (rd_row)
   );

   clf_scan #(
      .WAYS       (WAYS),
      .STAMP_BITS (STAMP_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .load       (scan_load),
      .row        (rd_row),
      .dirty_mask (mask_ff),
      .res        (scan_res)
   );

   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      rsp_way_in    = '0;
      rsp_valid_in  = 1'b0;
      rsp_fb_in     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (scan_load) begin
               state_in = ST_SCAN;
            end else begin
               // updates, invalidates and queries on a missing set answer now
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_valid_in  = is_victim;
            end
         end
         ST_SCAN: begin
            if (scan_res.done) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_way_in    = scan_res.way;
               rsp_fb_in     = scan_res.fallback;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_way_ff   <= rsp_way_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_fb_ff    <= rsp_fb_in;
      if (accept) begin
         op_ff   <= op_type'(req_op);
         set_ff  <= req_set_index;
         way_ff  <= req_way;
         now_ff  <= STAMP_BITS'(req_now);
         mask_ff <= req_dirty_mask;
      end
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_victim_way         = rsp_way_ff;
   assign rsp_victim_valid       = rsp_valid_ff;
   assign rsp_all_dirty_fallback = rsp_fb_ff;

   `CLF_ASSERT_NXT(a_accept_busy, clock, reset, accept, busy)
   `CLF_ASSERT_IMP(a_rsp_in_idle, clock, reset, rsp_strobe, state_ff == ST_IDLE)
   `CLF_ASSERT_IMP(a_scan_in_scan, clock, reset, scan_res.done, state_ff == ST_SCAN)
   `CLF_ASSERT_IMP(a_plain_rsp_zero, clock, reset, rsp_strobe && !rsp_victim_valid,
      rsp_victim_way == '0 && !rsp_all_dirty_fallback)

endmodule
